>>> sv/tmam_pkg.sv
package tmam_pkg;

   localparam int COUNT_BITS_DEF = 24;
   localparam int COORD_BITS_DEF = 16;

   // edge components are brought below 2^NORM_BITS before squaring
   localparam int NORM_BITS  = 17;
   localparam int SQ_BITS    = 2 * NORM_BITS + 2;
   localparam int LEN_BITS   = 31;
   localparam int NUM_BITS   = SQ_BITS + 3;
   localparam int DIV_BITS   = 64;
   localparam int ROOT_BITS  = DIV_BITS / 2;
   localparam int ROOT_STEPS = DIV_BITS / 2;
   localparam int LEN_PRE    = 26;
   localparam int COS_PRE    = 26;
   localparam int COS_FRAC   = 30;
   localparam int SUM_BITS   = 40;
   localparam int QUO_BITS   = SUM_BITS + 1;
   localparam int CORDIC_STEPS = 20;
   localparam int XY_BITS    = 34;
   localparam int Z_BITS     = 27;
   localparam int ATAN_BITS  = 22;
   localparam int Z_90       = 90 << 16;
   localparam int Z_180      = 180 << 16;
   localparam int ANGLE_BITS = 16;
   localparam int ANGLE_MAX  = 46080;
   localparam int STEP_BITS  = 6;
   localparam int OP_BITS    = 5;

   localparam logic [OP_BITS-1:0] OP_NONE      = 5'd0;
   localparam logic [OP_BITS-1:0] OP_LOAD      = 5'd1;
   localparam logic [OP_BITS-1:0] OP_MAG       = 5'd2;
   localparam logic [OP_BITS-1:0] OP_PREP      = 5'd3;
   localparam logic [OP_BITS-1:0] OP_SQ        = 5'd4;
   localparam logic [OP_BITS-1:0] OP_ROOT_LOAD = 5'd5;
   localparam logic [OP_BITS-1:0] OP_ROOT_STEP = 5'd6;
   localparam logic [OP_BITS-1:0] OP_LEN       = 5'd7;
   localparam logic [OP_BITS-1:0] OP_DEN       = 5'd8;
   localparam logic [OP_BITS-1:0] OP_DCHK      = 5'd9;
   localparam logic [OP_BITS-1:0] OP_DIV_STEP  = 5'd10;
   localparam logic [OP_BITS-1:0] OP_CSQ       = 5'd11;
   localparam logic [OP_BITS-1:0] OP_CINIT     = 5'd12;
   localparam logic [OP_BITS-1:0] OP_CSTEP     = 5'd13;
   localparam logic [OP_BITS-1:0] OP_ASTORE    = 5'd14;
   localparam logic [OP_BITS-1:0] OP_ACCUM     = 5'd15;
   localparam logic [OP_BITS-1:0] OP_MEAN_LOAD = 5'd16;
   localparam logic [OP_BITS-1:0] OP_FINISH    = 5'd17;

   typedef struct packed {
      logic [OP_BITS-1:0]   op;
      logic [1:0]           idx;
      logic [STEP_BITS-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic degen;
      logic cos_sat;
      logic last;
   } status_type;

   // arctangent of 2^-i in degrees Q6.16
   function automatic logic [ATAN_BITS-1:0] atan_q16(input logic [4:0] i);
      logic [ATAN_BITS-1:0] a;
      unique case (i)
         5'd0:  a = 22'd2949120;
         5'd1:  a = 22'd1740967;
         5'd2:  a = 22'd919879;
         5'd3:  a = 22'd466945;
         5'd4:  a = 22'd234379;
         5'd5:  a = 22'd117304;
         5'd6:  a = 22'd58666;
         5'd7:  a = 22'd29335;
         5'd8:  a = 22'd14668;
         5'd9:  a = 22'd7334;
         5'd10: a = 22'd3667;
         5'd11: a = 22'd1833;
         5'd12: a = 22'd917;
         5'd13: a = 22'd458;
         5'd14: a = 22'd229;
         5'd15: a = 22'd115;
         5'd16: a = 22'd57;
         5'd17: a = 22'd29;
         5'd18: a = 22'd14;
         5'd19: a = 22'd7;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

>>> sv/tmam_ifs.sv
interface tmam_req_if #(parameter int COORD_BITS = tmam_pkg::COORD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] p0_x;
   logic signed [COORD_BITS-1:0] p0_y;
   logic signed [COORD_BITS-1:0] p0_z;
   logic signed [COORD_BITS-1:0] p1_x;
   logic signed [COORD_BITS-1:0] p1_y;
   logic signed [COORD_BITS-1:0] p1_z;
   logic signed [COORD_BITS-1:0] p2_x;
   logic signed [COORD_BITS-1:0] p2_y;
   logic signed [COORD_BITS-1:0] p2_z;
   logic                         last_triangle;

   modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                   last_triangle, input ready);
   modport sink (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                 last_triangle, output ready);
endinterface

interface tmam_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] angle_at_p2;
   logic [15:0] angle_at_p0;
   logic [15:0] angle_at_p1;
   logic [15:0] smallest_angle;
   logic        degenerate;
   logic [15:0] mean_smallest_angle;
   logic        mean_valid;

   modport source (output valid, angle_at_p2, angle_at_p0, angle_at_p1, smallest_angle,
                   degenerate, mean_smallest_angle, mean_valid, input ready);
   modport sink (input valid, angle_at_p2, angle_at_p0, angle_at_p1, smallest_angle,
                 degenerate, mean_smallest_angle, mean_valid, output ready);
endinterface

>>> sv/triangle_min_angle_mean_top.sv
// Triangle minimum-angle statistic. Each request transfer carries one triangle as three
// signed 3D vertices; the response gives the three angles (law of cosines, degrees Q8.8),
// their minimum and a degenerate flag, and on the triangle marked last the rounded mean of
// the minimum angles of all non-degenerate triangles since the previous last, after which
// the running sum and count are cleared. One triangle is processed at a time by a shared
// sequential datapath: square root one bit pair per cycle, divider one quotient bit per
// cycle, CORDIC one rotation per cycle. An angle whose cosine saturates skips the division,
// a degenerate triangle skips the angle computation, and the last triangle adds the mean
// division; the block is ready for the next request once the result is registered, even
// while that result still awaits its transfer.
module triangle_min_angle_mean_top #(
   parameter int COUNT_BITS = tmam_pkg::COUNT_BITS_DEF,
   parameter int COORD_BITS = tmam_pkg::COORD_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   tmam_req_if.sink    req_if,
   tmam_rsp_if.source  rsp_if
);

   tmam_pkg::cmd_type               cmd;
   tmam_pkg::status_type            status;
   logic [2:0][2:0][COORD_BITS-1:0] coord_in;

   assign coord_in[0][0] = req_if.p0_x;
   assign coord_in[0][1] = req_if.p0_y;
   assign coord_in[0][2] = req_if.p0_z;
   assign coord_in[1][0] = req_if.p1_x;
   assign coord_in[1][1] = req_if.p1_y;
   assign coord_in[1][2] = req_if.p1_z;
   assign coord_in[2][0] = req_if.p2_x;
   assign coord_in[2][1] = req_if.p2_y;
   assign coord_in[2][2] = req_if.p2_z;

   tmam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tmam_dp #(
      .COORD_BITS (COORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .coord_in            (coord_in),
      .last_in             (req_if.last_triangle),
      .angle_at_p2         (rsp_if.angle_at_p2),
      .angle_at_p0         (rsp_if.angle_at_p0),
      .angle_at_p1         (rsp_if.angle_at_p1),
      .smallest_angle      (rsp_if.smallest_angle),
      .degenerate          (rsp_if.degenerate),
      .mean_smallest_angle (rsp_if.mean_smallest_angle),
      .mean_valid          (rsp_if.mean_valid)
   );

endmodule

>>> sv/tmam_dp.sv
module tmam_dp #(
   parameter int COORD_BITS = tmam_pkg::COORD_BITS_DEF,
   parameter int COUNT_BITS = tmam_pkg::COUNT_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tmam_pkg::cmd_type                     cmd,
   output tmam_pkg::status_type                  status,
   input  logic [2:0][2:0][COORD_BITS-1:0]       coord_in,
   input  logic                                  last_in,
   output logic [tmam_pkg::ANGLE_BITS-1:0]       angle_at_p2,
   output logic [tmam_pkg::ANGLE_BITS-1:0]       angle_at_p0,
   output logic [tmam_pkg::ANGLE_BITS-1:0]       angle_at_p1,
   output logic [tmam_pkg::ANGLE_BITS-1:0]       smallest_angle,
   output logic                                  degenerate,
   output logic [tmam_pkg::ANGLE_BITS-1:0]       mean_smallest_angle,
   output logic                                  mean_valid
);

   localparam int SH_BITS = $clog2(COORD_BITS + 1);
   localparam int NB  = tmam_pkg::NORM_BITS;
   localparam int SQB = tmam_pkg::SQ_BITS;
   localparam int LB  = tmam_pkg::LEN_BITS;
   localparam int NMB = tmam_pkg::NUM_BITS;
   localparam int DB  = tmam_pkg::DIV_BITS;
   localparam int RB  = tmam_pkg::ROOT_BITS;
   localparam int QB  = tmam_pkg::QUO_BITS;
   localparam int XYB = tmam_pkg::XY_BITS;
   localparam int ZB  = tmam_pkg::Z_BITS;
   localparam int AB  = tmam_pkg::ANGLE_BITS;
   localparam int SB  = tmam_pkg::SUM_BITS;
   localparam int CF  = tmam_pkg::COS_FRAC;

   function automatic logic [1:0] side_a(input logic [1:0] k);
      logic [1:0] r;
      unique case (k)
         2'd0:    r = 2'd1;
         2'd1:    r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] side_b(input logic [1:0] k);
      logic [1:0] r;
      unique case (k)
         2'd0:    r = 2'd2;
         2'd1:    r = 2'd0;
         default: r = 2'd1;
      endcase
      return r;
   endfunction

   logic [2:0][2:0][COORD_BITS-1:0] coord_ff;
   logic                            last_ff;
   logic [2:0][2:0][COORD_BITS-1:0] mag_ff, mag_in;
   logic                            degen_ff, degen_in;
   logic [2:0][2:0][NB-1:0]         norm_ff, norm_in;
   logic [2:0][SQB-1:0]             sq_ff;
   logic [SQB-1:0]                  sq_in;
   logic [2:0][LB-1:0]              len_ff;
   logic [DB-1:0]                   opnd_ff;
   logic [RB+1:0]                   srem_ff, srem_in;
   logic [RB-1:0]                   root_ff, root_in;
   logic                            num_neg_ff;
   logic                            cneg_ff;
   logic [CF:0]                     cmag_ff;
   logic [DB-1:0]                   den_ff, den_in;
   logic [DB-1:0]                   rem_ff, rem_in, rem_load;
   logic [QB-1:0]                   quo_ff, quo_in;
   logic [QB-1:0]                   dvd_ff;
   logic signed [NMB-1:0]           num_in;
   logic signed [XYB-1:0]           x_ff, y_ff, x_in, y_in;
   logic signed [ZB-1:0]            z_ff, z_in;
   logic [AB-1:0]                   angle_in;
   logic [2:0][AB-1:0]              angle_ff;
   logic [AB-1:0]                   amin;
   logic [SB-1:0]                   sum_ff;
   logic [COUNT_BITS-1:0]           count_ff;
   logic [DB-1:0]                   csq_opnd;
   logic [AB-1:0]                   mean_in;
   logic                            cos_sat;

   logic [AB-1:0] out_p2_ff, out_p0_ff, out_p1_ff, out_min_ff, out_mean_ff;
   logic          out_degen_ff, out_last_ff;

   // edge magnitudes: edge 0 = p0-p1, edge 1 = p1-p2, edge 2 = p0-p2
   always_comb begin
      logic signed [COORD_BITS:0] d;
      int va;
      int vb;
      degen_in = 1'b0;
      for (int e = 0; e < 3; e++) begin
         va = (e == 1) ? 1 : 0;
         vb = (e == 0) ? 1 : 2;
         for (int j = 0; j < 3; j++) begin
            d = $signed({coord_ff[va][j][COORD_BITS-1], coord_ff[va][j]})
              - $signed({coord_ff[vb][j][COORD_BITS-1], coord_ff[vb][j]});
            mag_in[e][j] = COORD_BITS'(d[COORD_BITS] ? -d : d);
         end
         if (mag_in[e] == '0)
            degen_in = 1'b1;
      end
   end

   // common right shift that brings every component below 2^NORM_BITS
   always_comb begin
      logic [COORD_BITS-1:0] orv;
      logic [SH_BITS-1:0]    blen;
      logic [SH_BITS-1:0]    sh;
      orv = '0;
      for (int e = 0; e < 3; e++)
         for (int j = 0; j < 3; j++)
            orv = orv | mag_ff[e][j];
      blen = '0;
      for (int b = 0; b < COORD_BITS; b++)
         if (orv[b])
            blen = SH_BITS'(b + 1);
      sh = (int'(blen) > NB) ? SH_BITS'(int'(blen) - NB) : '0;
      for (int e = 0; e < 3; e++)
         for (int j = 0; j < 3; j++)
            norm_in[e][j] = NB'(mag_ff[e][j] >> sh);
   end

   always_comb begin
      logic [NB-1:0]   v;
      logic [2*NB-1:0] vsq;
      v     = norm_ff[cmd.idx][cmd.step[1:0]];
      vsq   = v * v;
      sq_in = ((cmd.step == '0) ? '0 : sq_ff[cmd.idx]) + SQB'(vsq);
   end

   // restoring square root, one bit pair per step
   always_comb begin
      logic [RB+1:0] rt;
      logic [RB+1:0] trial;
      rt    = {srem_ff[RB-1:0], opnd_ff[DB-1 -: 2]};
      trial = {root_ff, 2'b01};
      if (rt >= trial) begin
         srem_in = rt - trial;
         root_in = {root_ff[RB-2:0], 1'b1};
      end else begin
         srem_in = rt;
         root_in = {root_ff[RB-2:0], 1'b0};
      end
   end

   always_comb begin
      logic [1:0]     ka;
      logic [1:0]     kb;
      logic [2*LB-1:0] prod;
      logic [NMB-2:0] nabs;
      ka     = side_a(cmd.idx);
      kb     = side_b(cmd.idx);
      num_in = $signed({3'b000, sq_ff[ka]}) + $signed({3'b000, sq_ff[kb]})
             - $signed({3'b000, sq_ff[cmd.idx]});
      prod   = len_ff[ka] * len_ff[kb];
      den_in = DB'({prod, 1'b0});
      nabs   = (NMB-1)'(num_in[NMB-1] ? -num_in : num_in);
      rem_load = DB'({nabs, {tmam_pkg::COS_PRE{1'b0}}});
   end

   assign cos_sat = (den_ff == '0) || (rem_ff >= den_ff);

   // shared restoring divider, one quotient bit per step
   always_comb begin
      logic [DB-1:0] dt;
      dt = {rem_ff[DB-2:0], dvd_ff[QB-1]};
      if (dt >= den_ff) begin
         rem_in = dt - den_ff;
         quo_in = {quo_ff[QB-2:0], 1'b1};
      end else begin
         rem_in = dt;
         quo_in = {quo_ff[QB-2:0], 1'b0};
      end
   end

   always_comb begin
      logic [2*(CF+1)-1:0] csq;
      csq      = quo_ff[CF:0] * quo_ff[CF:0];
      csq_opnd = (DB'(1) << (2 * CF)) - DB'(csq);
   end

   // vectoring CORDIC step; shifts round towards minus infinity
   always_comb begin
      logic [4:0]            i;
      logic signed [XYB-1:0] xs;
      logic signed [XYB-1:0] ys;
      logic signed [ZB-1:0]  at;
      i  = cmd.step[4:0];
      xs = x_ff >>> i;
      ys = y_ff >>> i;
      at = $signed({{(ZB - tmam_pkg::ATAN_BITS){1'b0}}, tmam_pkg::atan_q16(i)});
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (y_ff > 0) begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + at;
      end else if (y_ff < 0) begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - at;
      end
   end

   always_comb begin
      logic signed [ZB-1:0] zc;
      logic [ZB-1:0]        zr;
      if (z_ff < 0)
         zc = '0;
      else if (z_ff > ZB'(tmam_pkg::Z_180))
         zc = ZB'(tmam_pkg::Z_180);
      else
         zc = z_ff;
      zr = ZB'(zc) + ZB'(128);
      if (zr[ZB-1:8] > (ZB-8)'(tmam_pkg::ANGLE_MAX))
         angle_in = AB'(tmam_pkg::ANGLE_MAX);
      else
         angle_in = AB'(zr[ZB-1:8]);
   end

   always_comb begin
      amin = angle_ff[0];
      if (angle_ff[1] < amin)
         amin = angle_ff[1];
      if (angle_ff[2] < amin)
         amin = angle_ff[2];
   end

   always_comb begin
      if (!last_ff || count_ff == '0)
         mean_in = '0;
      else if (quo_ff > QB'(tmam_pkg::ANGLE_MAX))
         mean_in = AB'(tmam_pkg::ANGLE_MAX);
      else
         mean_in = AB'(quo_ff);
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         tmam_pkg::OP_LOAD: begin
            coord_ff <= coord_in;
            last_ff  <= last_in;
            angle_ff <= '0;
         end
         tmam_pkg::OP_MAG: begin
            mag_ff   <= mag_in;
            degen_ff <= degen_in;
         end
         tmam_pkg::OP_PREP:
            norm_ff <= norm_in;
         tmam_pkg::OP_SQ:
            sq_ff[cmd.idx] <= sq_in;
         tmam_pkg::OP_ROOT_LOAD: begin
            opnd_ff <= DB'({sq_ff[cmd.idx], {tmam_pkg::LEN_PRE{1'b0}}});
            srem_ff <= '0;
            root_ff <= '0;
         end
         tmam_pkg::OP_ROOT_STEP: begin
            opnd_ff <= {opnd_ff[DB-3:0], 2'b00};
            srem_ff <= srem_in;
            root_ff <= root_in;
         end
         tmam_pkg::OP_LEN:
            len_ff[cmd.idx] <= LB'(root_ff);
         tmam_pkg::OP_DEN: begin
            den_ff     <= den_in;
            rem_ff     <= rem_load;
            num_neg_ff <= num_in[NMB-1];
            quo_ff     <= '0;
            dvd_ff     <= '0;
         end
         tmam_pkg::OP_DCHK: begin
            // cosine reaches one, or a side vanished after the shift
            if (cos_sat)
               quo_ff <= QB'(1) << CF;
            cneg_ff <= num_neg_ff && (den_ff != '0);
         end
         tmam_pkg::OP_DIV_STEP: begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            dvd_ff <= {dvd_ff[QB-2:0], 1'b0};
         end
         tmam_pkg::OP_CSQ: begin
            cmag_ff <= quo_ff[CF:0];
            opnd_ff <= csq_opnd;
            srem_ff <= '0;
            root_ff <= '0;
         end
         tmam_pkg::OP_CINIT: begin
            // negative cosine: pre-rotate by 90 degrees
            if (cneg_ff) begin
               x_ff <= $signed({2'b00, root_ff});
               y_ff <= $signed({{(XYB-CF-1){1'b0}}, cmag_ff});
               z_ff <= ZB'(tmam_pkg::Z_90);
            end else begin
               x_ff <= $signed({{(XYB-CF-1){1'b0}}, cmag_ff});
               y_ff <= $signed({2'b00, root_ff});
               z_ff <= '0;
            end
         end
         tmam_pkg::OP_CSTEP: begin
            x_ff <= x_in;
            y_ff <= y_in;
            z_ff <= z_in;
         end
         tmam_pkg::OP_ASTORE:
            angle_ff[cmd.idx] <= angle_in;
         tmam_pkg::OP_MEAN_LOAD: begin
            dvd_ff <= QB'(sum_ff) + QB'(count_ff >> 1);
            rem_ff <= '0;
            quo_ff <= '0;
            den_ff <= DB'(count_ff);
         end
         tmam_pkg::OP_FINISH: begin
            out_p2_ff    <= angle_ff[0];
            out_p0_ff    <= angle_ff[1];
            out_p1_ff    <= angle_ff[2];
            out_min_ff   <= amin;
            out_degen_ff <= degen_ff;
            out_mean_ff  <= mean_in;
            out_last_ff  <= last_ff;
         end
         default: ;
      endcase
   end

   // running statistic; the last triangle is counted before the mean is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.op == tmam_pkg::OP_ACCUM && !degen_ff) begin
         if (sum_ff > ({SB{1'b1}} - SB'(amin)))
            sum_ff <= {SB{1'b1}};
         else
            sum_ff <= sum_ff + SB'(amin);
         if (count_ff != {COUNT_BITS{1'b1}})
            count_ff <= count_ff + 1'b1;
      end else if (cmd.op == tmam_pkg::OP_FINISH && last_ff) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end
   end

   assign status.degen   = degen_ff;
   assign status.cos_sat = cos_sat;
   assign status.last    = last_ff;

   assign angle_at_p2         = out_p2_ff;
   assign angle_at_p0         = out_p0_ff;
   assign angle_at_p1         = out_p1_ff;
   assign smallest_angle      = out_min_ff;
   assign degenerate          = out_degen_ff;
   assign mean_smallest_angle = out_mean_ff;
   assign mean_valid          = out_last_ff;

endmodule

>>> sv/tmam_ctrl.sv
module tmam_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tmam_pkg::status_type status,
   output tmam_pkg::cmd_type    cmd
);

   localparam int SW = 5;
   localparam logic [SW-1:0] S_IDLE   = 5'd0;
   localparam logic [SW-1:0] S_MAG    = 5'd1;
   localparam logic [SW-1:0] S_PREP   = 5'd2;
   localparam logic [SW-1:0] S_SQ     = 5'd3;
   localparam logic [SW-1:0] S_RLOAD  = 5'd4;
   localparam logic [SW-1:0] S_RSTEP  = 5'd5;
   localparam logic [SW-1:0] S_LEN    = 5'd6;
   localparam logic [SW-1:0] S_DEN    = 5'd7;
   localparam logic [SW-1:0] S_DCHK   = 5'd8;
   localparam logic [SW-1:0] S_DSTEP  = 5'd9;
   localparam logic [SW-1:0] S_CSQ    = 5'd10;
   localparam logic [SW-1:0] S_ASTEP  = 5'd11;
   localparam logic [SW-1:0] S_CINIT  = 5'd12;
   localparam logic [SW-1:0] S_CSTEP  = 5'd13;
   localparam logic [SW-1:0] S_ASTORE = 5'd14;
   localparam logic [SW-1:0] S_ACCUM  = 5'd15;
   localparam logic [SW-1:0] S_MLOAD  = 5'd16;
   localparam logic [SW-1:0] S_MSTEP  = 5'd17;
   localparam logic [SW-1:0] S_DONE   = 5'd18;

   localparam int STB = tmam_pkg::STEP_BITS;
   localparam logic [STB-1:0] LAST_ROOT = STB'(tmam_pkg::ROOT_STEPS - 1);
   localparam logic [STB-1:0] LAST_COS  = STB'(tmam_pkg::COS_FRAC - 1);
   localparam logic [STB-1:0] LAST_ROT  = STB'(tmam_pkg::CORDIC_STEPS - 1);
   localparam logic [STB-1:0] LAST_MEAN = STB'(tmam_pkg::QUO_BITS - 1);

   logic [SW-1:0]  state_ff, state_in;
   logic [1:0]     idx_ff, idx_in;
   logic [STB-1:0] step_ff, step_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      step_in  = step_ff;
      cmd.op   = tmam_pkg::OP_NONE;
      cmd.idx  = idx_ff;
      cmd.step = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = tmam_pkg::OP_LOAD;
               state_in = S_MAG;
            end
         end
         S_MAG: begin
            cmd.op   = tmam_pkg::OP_MAG;
            state_in = S_PREP;
         end
         S_PREP: begin
            if (status.degen) begin
               state_in = S_ACCUM;
            end else begin
               cmd.op   = tmam_pkg::OP_PREP;
               idx_in   = '0;
               step_in  = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            cmd.op = tmam_pkg::OP_SQ;
            if (step_ff == STB'(2)) begin
               step_in = '0;
               if (idx_ff == 2'd2) begin
                  idx_in   = '0;
                  state_in = S_RLOAD;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_RLOAD: begin
            cmd.op   = tmam_pkg::OP_ROOT_LOAD;
            step_in  = '0;
            state_in = S_RSTEP;
         end
         S_RSTEP: begin
            cmd.op = tmam_pkg::OP_ROOT_STEP;
            if (step_ff == LAST_ROOT) begin
               step_in  = '0;
               state_in = S_LEN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_LEN: begin
            cmd.op = tmam_pkg::OP_LEN;
            if (idx_ff == 2'd2) begin
               idx_in   = '0;
               state_in = S_DEN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_RLOAD;
            end
         end
         S_DEN: begin
            cmd.op   = tmam_pkg::OP_DEN;
            state_in = S_DCHK;
         end
         S_DCHK: begin
            cmd.op   = tmam_pkg::OP_DCHK;
            step_in  = '0;
            state_in = status.cos_sat ? S_CSQ : S_DSTEP;
         end
         S_DSTEP: begin
            cmd.op = tmam_pkg::OP_DIV_STEP;
            if (step_ff == LAST_COS) begin
               step_in  = '0;
               state_in = S_CSQ;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_CSQ: begin
            cmd.op   = tmam_pkg::OP_CSQ;
            step_in  = '0;
            state_in = S_ASTEP;
         end
         S_ASTEP: begin
            cmd.op = tmam_pkg::OP_ROOT_STEP;
            if (step_ff == LAST_ROOT) begin
               step_in  = '0;
               state_in = S_CINIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_CINIT: begin
            cmd.op   = tmam_pkg::OP_CINIT;
            step_in  = '0;
            state_in = S_CSTEP;
         end
         S_CSTEP: begin
            cmd.op = tmam_pkg::OP_CSTEP;
            if (step_ff == LAST_ROT) begin
               step_in  = '0;
               state_in = S_ASTORE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_ASTORE: begin
            cmd.op = tmam_pkg::OP_ASTORE;
            if (idx_ff == 2'd2) begin
               idx_in   = '0;
               state_in = S_ACCUM;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_DEN;
            end
         end
         S_ACCUM: begin
            cmd.op   = tmam_pkg::OP_ACCUM;
            state_in = status.last ? S_MLOAD : S_DONE;
         end
         S_MLOAD: begin
            cmd.op   = tmam_pkg::OP_MEAN_LOAD;
            step_in  = '0;
            state_in = S_MSTEP;
         end
         S_MSTEP: begin
            cmd.op = tmam_pkg::OP_DIV_STEP;
            if (step_ff == LAST_MEAN) begin
               step_in  = '0;
               state_in = S_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_DONE: begin
            // output register free, or its transfer completes this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = tmam_pkg::OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.op == tmam_pkg::OP_FINISH)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == tmam_pkg::OP_FINISH) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded while holding an untaken result");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == tmam_pkg::OP_FINISH) |=> rsp_valid_ff)
      else $error("finished result not presented");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (step_ff <= LAST_MEAN) && (idx_ff != 2'd3))
      else $error("sequencer counter out of range");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_MAG))
      else $error("accepted triangle not started");

endmodule

>>> sim/tmam_tb_ifs.sv
`timescale 1ns / 1ps
// The block's request and response interfaces live in sv/tmam_ifs.sv. This file holds the
// testbench's own result record, shared by the predictor and the checker.
package tmam_tb_pkg;
   typedef struct packed {
      logic [15:0] angle_at_p2;
      logic [15:0] angle_at_p0;
      logic [15:0] angle_at_p1;
      logic [15:0] smallest_angle;
      logic        degenerate;
      logic [15:0] mean_smallest_angle;
      logic        mean_valid;
   } angle_result_type;
endpackage

>>> sim/triangle_min_angle_mean_top_tb.sv
`timescale 1ns / 1ps
module triangle_min_angle_mean_top_tb;

   localparam int LIMIT_CYCLES = 2_000_000;

   typedef struct {
      logic signed [15:0] c [9];
      logic               last;
   } triangle_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tmam_req_if #(.COORD_BITS(16)) req_if ();
   tmam_rsp_if rsp_if ();

   triangle_min_angle_mean_top dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   triangle_type                  pending_tris [$];
   tmam_tb_pkg::angle_result_type expected_angles [$];
   logic [63:0]   min_angle_sum;
   logic [63:0]   counted_tris;
   int            send_idle_pct = 28;
   int            recv_idle_pct = 61;
   int            errors = 0;
   int            cycle_count = 0;
   bit            timed_out = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // floor shift for signed values
   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic [63:0] isqrt64(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint cos_q30(longint num, logic [63:0] lp, logic [63:0] lq);
      logic [63:0] den;
      logic [63:0] rem;
      logic [63:0] q;
      logic [63:0] mg;
      den = 2 * lp * lq;
      q = 0;
      if (den == 0) return longint'(1) << 30;
      mg = (num < 0) ? -num : num;
      rem = mg << 26;
      if (rem >= den) begin
         q = 64'd1 << 30;
      end else begin
         for (int i = 0; i < 30; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
               rem = rem - den;
               q[0] = 1'b1;
            end
         end
      end
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [15:0] arccos_deg(longint c);
      longint cm;
      longint x;
      longint y;
      longint z;
      longint nx;
      longint ny;
      longint t;
      cm = (c < 0) ? -c : c;
      x = c;
      y = longint'(isqrt64((64'd1 << 60) - cm * cm));
      z = 0;
      if (x < 0) begin
         t = x;
         x = y;
         y = -t;
         z = longint'(tmam_pkg::Z_90);
      end
      for (int i = 0; i < tmam_pkg::CORDIC_STEPS && y != 0; i++) begin
         if (y > 0) begin
            nx = x + fshift(y, i);
            ny = y - fshift(x, i);
            z = z + longint'(tmam_pkg::atan_q16(5'(i)));
         end else begin
            nx = x - fshift(y, i);
            ny = y + fshift(x, i);
            z = z - longint'(tmam_pkg::atan_q16(5'(i)));
         end
         x = nx;
         y = ny;
      end
      if (z < 0) z = 0;
      if (z > longint'(tmam_pkg::Z_180)) z = longint'(tmam_pkg::Z_180);
      z = (z + 128) >>> 8;
      if (z > tmam_pkg::ANGLE_MAX) z = longint'(tmam_pkg::ANGLE_MAX);
      return z[15:0];
   endfunction

   function automatic tmam_tb_pkg::angle_result_type predict_angles(triangle_type t);
      tmam_tb_pkg::angle_result_type r;
      longint      d [3][3];
      logic [63:0] sq [3];
      logic [63:0] ln [3];
      logic [63:0] smax;
      logic [63:0] cmax;
      logic [63:0] mn;
      r = '0;
      for (int j = 0; j < 3; j++) begin
         d[0][j] = longint'(t.c[j]) - longint'(t.c[3 + j]);
         d[1][j] = longint'(t.c[3 + j]) - longint'(t.c[6 + j]);
         d[2][j] = longint'(t.c[j]) - longint'(t.c[6 + j]);
      end
      for (int i = 0; i < 3; i++) begin
         if (d[i][0] == 0 && d[i][1] == 0 && d[i][2] == 0) r.degenerate = 1'b1;
      end
      // 16-bit coordinates never need the normalising shift
      if (!r.degenerate) begin
         for (int i = 0; i < 3; i++) begin
            sq[i] = d[i][0] * d[i][0] + d[i][1] * d[i][1] + d[i][2] * d[i][2];
            ln[i] = isqrt64(sq[i] << 26);
         end
         r.angle_at_p2 = arccos_deg(cos_q30(sq[1] + sq[2] - sq[0], ln[1], ln[2]));
         r.angle_at_p0 = arccos_deg(cos_q30(sq[2] + sq[0] - sq[1], ln[2], ln[0]));
         r.angle_at_p1 = arccos_deg(cos_q30(sq[0] + sq[1] - sq[2], ln[0], ln[1]));
         mn = 64'(r.angle_at_p2);
         if (r.angle_at_p0 < mn) mn = 64'(r.angle_at_p0);
         if (r.angle_at_p1 < mn) mn = 64'(r.angle_at_p1);
         r.smallest_angle = mn[15:0];
         smax = (64'd1 << tmam_pkg::SUM_BITS) - 1;
         cmax = (64'd1 << tmam_pkg::COUNT_BITS_DEF) - 1;
         min_angle_sum = (min_angle_sum > smax - mn) ? smax : min_angle_sum + mn;
         if (counted_tris < cmax) counted_tris = counted_tris + 1;
      end
      r.mean_valid = t.last;
      if (t.last) begin
         if (counted_tris != 0) begin
            mn = (min_angle_sum + counted_tris / 2) / counted_tris;
            if (mn > tmam_pkg::ANGLE_MAX) mn = 64'(tmam_pkg::ANGLE_MAX);
            r.mean_smallest_angle = mn[15:0];
         end
         min_angle_sum = 0;
         counted_tris = 0;
      end
      return r;
   endfunction

   function automatic triangle_type make_tri(int v [9], logic last);
      triangle_type t;
      for (int i = 0; i < 9; i++) t.c[i] = v[i][15:0];
      t.last = last;
      return t;
   endfunction

   function automatic void queue_tri(triangle_type t);
      pending_tris = {pending_tris, t};
   endfunction

   // random coordinate: mostly small meshes, sometimes full range
   function automatic int rand_coord(int span);
      return $urandom_range(2 * span) - span;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (pending_tris.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            triangle_type t;
            t = pending_tris.pop_front();
            expected_angles = {expected_angles, predict_angles(t)};
            req_if.valid <= 1'b1;
            {req_if.p0_x, req_if.p0_y, req_if.p0_z} <= {t.c[0], t.c[1], t.c[2]};
            {req_if.p1_x, req_if.p1_y, req_if.p1_z} <= {t.c[3], t.c[4], t.c[5]};
            {req_if.p2_x, req_if.p2_y, req_if.p2_z} <= {t.c[6], t.c[7], t.c[8]};
            req_if.last_triangle <= t.last;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // monitor and response stalls
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_angles.size() == 0) begin
               $display("%0t: unexpected transfer, actual %p", $time, rsp_if.angle_at_p2);
               errors <= errors + 1;
            end else begin
               tmam_tb_pkg::angle_result_type e;
               tmam_tb_pkg::angle_result_type a;
               e = expected_angles.pop_front();
               a.angle_at_p2 = rsp_if.angle_at_p2;
               a.angle_at_p0 = rsp_if.angle_at_p0;
               a.angle_at_p1 = rsp_if.angle_at_p1;
               a.smallest_angle = rsp_if.smallest_angle;
               a.degenerate = rsp_if.degenerate;
               a.mean_smallest_angle = rsp_if.mean_smallest_angle;
               a.mean_valid = rsp_if.mean_valid;
               if (a !== e) begin
                  $display("%0t: expected %p actual %p", $time, e, a);
                  errors <= errors + 1;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      int v [9];
      int span;
      min_angle_sum = 0;
      counted_tris = 0;

      // directed: last with no count, degenerate forms, extremes, right/flat/obtuse
      queue_tri(make_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1));
      queue_tri(make_tri('{1, 2, 3, 1, 2, 3, 5, 5, 5}, 1'b0));
      queue_tri(make_tri('{1, 2, 3, 4, 4, 4, 4, 4, 4}, 1'b0));
      queue_tri(make_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0}, 1'b0));
      queue_tri(make_tri('{0, 0, 0, 2, 0, 0, 1, 0, 0}, 1'b0));
      queue_tri(make_tri('{0, 0, 0, 100, 0, 0, 50, 1, 0}, 1'b0));
      queue_tri(make_tri('{-32768, -32768, -32768, 32767, 32767, 32767,
                           32767, -32768, 0}, 1'b0));
      queue_tri(make_tri('{32767, 0, 0, -32768, 0, 0, 0, 32767, -32768}, 1'b0));
      queue_tri(make_tri('{-32768, 32767, -1, 0, -32768, 32767,
                           32767, 0, -32768}, 1'b0));
      queue_tri(make_tri('{0, 0, 0, 1, 1, 1, 32767, 32767, 32766}, 1'b0));
      queue_tri(make_tri('{0, 0, 0, 3, 0, 0, 0, 4, 0}, 1'b1));
      queue_tri(make_tri('{5, 5, 5, 5, 5, 5, 5, 5, 5}, 1'b1));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < 950; n++) begin
         if (n == 317) begin
            send_idle_pct = 61;
            recv_idle_pct = 28;
         end else if (n == 634) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case ($urandom_range(9))
            0:       span = 32767;
            1:       span = 2;
            default: span = $urandom_range(1000, 10);
         endcase
         for (int i = 0; i < 9; i++) v[i] = rand_coord(span);
         if ($urandom_range(19) == 0) begin
            for (int i = 0; i < 3; i++) v[3 + i] = v[i];
         end
         if (span == 32767 && $urandom_range(1)) begin
            for (int i = 0; i < 9; i++) v[i] = $urandom_range(1) ? 32767 : -32768;
         end
         queue_tri(make_tri(v, $urandom_range(24) == 0));
         // keep the queue short so idling mode applies to what is sent
         while (pending_tris.size() > 4) @(posedge clock);
      end
      queue_tri(make_tri('{0, 0, 0, 7, 0, 0, 0, 9, 0}, 1'b1));

      while ((pending_tris.size() != 0 || expected_angles.size() != 0) && !timed_out)
         @(posedge clock);
      repeat (500) @(posedge clock);
      if (!timed_out) begin
         if (errors == 0 && expected_angles.size() == 0) begin
            $display("SCOREBOARD CLEAN");
         end else begin
            $display("SCOREBOARD MISMATCH");
         end
         $finish;
      end
   end

   always @(posedge clock) begin
      if (cycle_count == LIMIT_CYCLES && !timed_out) begin
         timed_out = 1;
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
